// ----- rtl/nclf_pkg.sv -----
// Shared types and constants of the nearest cluster leg finder.
package nclf_pkg;

  localparam int RANGE_W    = 16;
  localparam int OFS_W      = 10;
  localparam int RAD_W      = 24;
  localparam int HITS_W     = 11;
  localparam int IDX_OUT_W  = 11;
  localparam int ANGLE_W    = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 112;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_NEAR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_BELOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_OFS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RAD_STEP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS    = 3'd7;

  // Request kinds carried in tuser
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [RANGE_W-1:0] DIST_MAX  = '1;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIDE,
    ST_WAIT,
    ST_MUL,
    ST_LATCH,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PASS_NEAR,
    PASS_COUNT,
    PASS_PICK
  } pass_e;

  typedef enum logic {
    SIDE_RIGHT,
    SIDE_LEFT
  } side_e;

  typedef struct packed {
    logic  load;
    logic  last;
    logic  clr_count;
    logic  restart;
    logic  pass_start;
    pass_e kind;
    side_e side;
    logic  mul;
    logic  latch;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic busy;
    logic near_ok;
    logic hits_ok;
    logic right_latched;
    logic left_latched;
    logic out_busy;
  } status_t;

endpackage

// ----- rtl/nclf_ctrl.sv -----
// Controller state machine: sample loading, search pass sequencing, result emission.
module nclf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tuser,
  input  logic              s_axis_tlast,
  output logic              s_axis_tready,
  input  nclf_pkg::status_t status_i,
  output nclf_pkg::cmd_t    cmd_o
);

  nclf_pkg::state_e state_q, state_d;
  nclf_pkg::side_e  side_q, side_d;
  nclf_pkg::pass_e  kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nclf_pkg::ST_IDLE;
      side_q  <= nclf_pkg::SIDE_RIGHT;
      kind_q  <= nclf_pkg::PASS_NEAR;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    logic adv;
    logic side_done;
    adv           = 1'b0;
    side_done     = (side_q == nclf_pkg::SIDE_RIGHT) ? status_i.right_latched
                                                     : status_i.left_latched;
    state_d       = state_q;
    side_d        = side_q;
    kind_d        = kind_q;
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    cmd_o.side    = side_q;
    cmd_o.kind    = kind_q;

    case (state_q)
      nclf_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == nclf_pkg::OP_RESTART) begin
            cmd_o.restart = 1'b1;
          end else if (!status_i.enable) begin
            cmd_o.clr_count = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            cmd_o.last = s_axis_tlast;
            if (s_axis_tlast) begin
              side_d  = nclf_pkg::SIDE_RIGHT;
              state_d = nclf_pkg::ST_SIDE;
            end
          end
        end
      end
      nclf_pkg::ST_SIDE: begin
        if (side_done) begin
          adv = 1'b1;
        end else begin
          cmd_o.pass_start = 1'b1;
          cmd_o.kind       = nclf_pkg::PASS_NEAR;
          kind_d           = nclf_pkg::PASS_NEAR;
          state_d          = nclf_pkg::ST_WAIT;
        end
      end
      nclf_pkg::ST_WAIT: begin
        if (!status_i.busy) begin
          case (kind_q)
            nclf_pkg::PASS_NEAR: begin
              if (status_i.near_ok) begin
                cmd_o.pass_start = 1'b1;
                cmd_o.kind       = nclf_pkg::PASS_COUNT;
                kind_d           = nclf_pkg::PASS_COUNT;
              end else begin
                adv = 1'b1;
              end
            end
            nclf_pkg::PASS_COUNT: begin
              if (status_i.hits_ok) begin
                cmd_o.pass_start = 1'b1;
                cmd_o.kind       = nclf_pkg::PASS_PICK;
                kind_d           = nclf_pkg::PASS_PICK;
              end else begin
                adv = 1'b1;
              end
            end
            nclf_pkg::PASS_PICK: begin
              state_d = nclf_pkg::ST_MUL;
            end
            default: begin
              adv = 1'b1;
            end
          endcase
        end
      end
      nclf_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = nclf_pkg::ST_LATCH;
      end
      nclf_pkg::ST_LATCH: begin
        cmd_o.latch = 1'b1;
        adv         = 1'b1;
      end
      nclf_pkg::ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = nclf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nclf_pkg::ST_IDLE;
      end
    endcase

    // right half done: go on with the left one; left done: report
    if (adv) begin
      if (side_q == nclf_pkg::SIDE_RIGHT) begin
        side_d  = nclf_pkg::SIDE_LEFT;
        state_d = nclf_pkg::ST_SIDE;
      end else begin
        state_d = nclf_pkg::ST_EMIT;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pass_start |-> !status_i.busy)
    else $error("pass started while pass engine busy");

  a_mul_after_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |-> kind_q == nclf_pkg::PASS_PICK && $past(state_q) == nclf_pkg::ST_WAIT)
    else $error("angle multiply without pick pass");

endmodule

// ----- rtl/nclf_dp.sv -----
// Datapath: config registers, scan memory, search pass engine, leg latches, output register.
module nclf_dp #(
  parameter int MAX_POINTS = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nclf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nclf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [nclf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  nclf_pkg::cmd_t                    cmd_i,
  output nclf_pkg::status_t                 status_o,
  input  logic                              m_axis_tready,
  output logic                              m_axis_tvalid,
  output logic [nclf_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int IW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int PW    = nclf_pkg::RAD_W + CW;
  localparam int RW    = nclf_pkg::RANGE_W;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_POINTS);

  // configuration
  logic                          enable_q;
  logic [RW-1:0]                 min_valid_q, init_near_q, accept_q, band_q;
  logic [nclf_pkg::OFS_W-1:0]    ofs_q;
  logic [nclf_pkg::RAD_W-1:0]    rad_q;
  logic [nclf_pkg::HITS_W-1:0]   min_hits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      min_valid_q <= 16'd50;
      init_near_q <= 16'd1300;
      accept_q    <= 16'd1200;
      band_q      <= 16'd100;
      ofs_q       <= 10'd21;
      rad_q       <= 24'd96630;
      min_hits_q  <= 11'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nclf_pkg::CFG_ENABLE:       enable_q    <= cfg_data_i[0];
        nclf_pkg::CFG_MIN_VALID:    min_valid_q <= cfg_data_i[RW-1:0];
        nclf_pkg::CFG_INIT_NEAR:    init_near_q <= cfg_data_i[RW-1:0];
        nclf_pkg::CFG_ACCEPT_BELOW: accept_q    <= cfg_data_i[RW-1:0];
        nclf_pkg::CFG_BAND:         band_q      <= cfg_data_i[RW-1:0];
        nclf_pkg::CFG_DIST_OFS:     ofs_q       <= cfg_data_i[nclf_pkg::OFS_W-1:0];
        nclf_pkg::CFG_RAD_STEP:     rad_q       <= cfg_data_i[nclf_pkg::RAD_W-1:0];
        nclf_pkg::CFG_MIN_HITS:     min_hits_q  <= cfg_data_i[nclf_pkg::HITS_W-1:0];
        default: ;
      endcase
    end
  end

  // sample loading
  logic [RW-1:0] s_range;
  logic          s_valid;
  logic [CW-1:0] count_q, n_q;
  logic          room;

  assign s_range = s_axis_tdata[RW-1:0];
  assign s_valid = s_axis_tdata[RW];
  assign room    = count_q < MaxCount;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clr_count || (cmd_i.load && cmd_i.last)) begin
      count_q <= '0;
    end else if (cmd_i.load && room) begin
      count_q <= count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && cmd_i.last) begin
      n_q <= room ? count_q + CW'(1) : count_q;
    end
  end

  // pass bounds
  logic [CW-1:0] cidx, lo, hi;
  assign cidx = n_q >> 1;
  assign lo   = (cmd_i.side == nclf_pkg::SIDE_RIGHT) ? '0 : cidx;
  assign hi   = (cmd_i.side == nclf_pkg::SIDE_RIGHT) ? cidx : n_q;

  // pass engine: one memory read per cycle, read data registered before evaluation
  logic [RW:0]     mem [MAX_POINTS];
  logic [RW:0]     rd_q;
  logic            run_q, rdv_q;
  logic [CW-1:0]   addr_q, addr_next, rd_idx_q;
  nclf_pkg::pass_e kind_q;

  assign addr_next = addr_q + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      rdv_q  <= 1'b0;
      kind_q <= nclf_pkg::PASS_NEAR;
    end else begin
      rdv_q <= run_q;
      if (cmd_i.pass_start) begin
        run_q  <= lo != hi;
        kind_q <= cmd_i.kind;
      end else if (run_q && addr_next == hi) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (cmd_i.pass_start) begin
      addr_q <= lo;
    end else if (run_q) begin
      addr_q <= addr_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      mem[count_q[IW-1:0]] <= {s_valid, s_range};
    end
    if (run_q) begin
      rd_q <= mem[addr_q[IW-1:0]];
    end
  end

  // evaluation of one stored sample
  logic [RW-1:0] rd_range, near_q, pick_range_q;
  logic [RW:0]   lim;
  logic          cand, in_band, pick_found_q;
  logic [CW-1:0] hits_q, seen_q, pick_idx_q, pick;

  assign rd_range = rd_q[RW-1:0];
  assign cand     = rd_q[RW] && (rd_range > min_valid_q);
  assign lim      = {1'b0, near_q} + {1'b0, band_q};
  assign in_band  = cand && ({1'b0, rd_range} < lim);
  assign pick     = hits_q >> 1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pass_start) begin
      case (cmd_i.kind)
        nclf_pkg::PASS_NEAR:  near_q <= init_near_q;
        nclf_pkg::PASS_COUNT: hits_q <= '0;
        nclf_pkg::PASS_PICK:  seen_q <= '0;
        default: ;
      endcase
    end else if (rdv_q) begin
      case (kind_q)
        nclf_pkg::PASS_NEAR: begin
          if (cand && rd_range < near_q) near_q <= rd_range;
        end
        nclf_pkg::PASS_COUNT: begin
          if (in_band) hits_q <= hits_q + CW'(1);
        end
        nclf_pkg::PASS_PICK: begin
          if (in_band) begin
            if (seen_q == pick) begin
              pick_idx_q   <= rd_idx_q;
              pick_range_q <= rd_range;
            end
            seen_q <= seen_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_found_q <= 1'b0;
    end else if (cmd_i.pass_start && cmd_i.kind == nclf_pkg::PASS_PICK) begin
      pick_found_q <= 1'b0;
    end else if (rdv_q && kind_q == nclf_pkg::PASS_PICK && in_band && seen_q == pick) begin
      pick_found_q <= 1'b1;
    end
  end

  // angle and distance of the picked hit
  logic [CW-1:0]                steps;
  logic [PW-1:0]                prod_q;
  logic [nclf_pkg::ANGLE_W-1:0] angle_sat;
  logic [RW:0]                  dist_sum;
  logic [RW-1:0]                dist_sat;

  assign steps     = (cmd_i.side == nclf_pkg::SIDE_RIGHT) ? cidx - pick_idx_q
                                                          : pick_idx_q - cidx;
  assign angle_sat = (prod_q > PW'(nclf_pkg::ANGLE_MAX)) ? nclf_pkg::ANGLE_MAX
                                                         : prod_q[nclf_pkg::ANGLE_W-1:0];
  assign dist_sum  = {1'b0, pick_range_q} + (RW+1)'(ofs_q);
  assign dist_sat  = dist_sum[RW] ? nclf_pkg::DIST_MAX : dist_sum[RW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PW'(rad_q) * PW'(steps);
    end
  end

  // leg latches
  logic                           r_lat_q, l_lat_q;
  logic [nclf_pkg::IDX_OUT_W-1:0] r_idx_q, l_idx_q;
  logic [RW-1:0]                  r_dist_q, l_dist_q;
  logic [nclf_pkg::ANGLE_W-1:0]   r_ang_q, l_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_lat_q <= 1'b0;
      l_lat_q <= 1'b0;
    end else if (cmd_i.restart) begin
      r_lat_q <= 1'b0;
      l_lat_q <= 1'b0;
    end else if (cmd_i.latch) begin
      if (cmd_i.side == nclf_pkg::SIDE_RIGHT) r_lat_q <= 1'b1;
      else                                    l_lat_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      if (cmd_i.side == nclf_pkg::SIDE_RIGHT) begin
        r_idx_q  <= nclf_pkg::IDX_OUT_W'(pick_idx_q);
        r_dist_q <= dist_sat;
        r_ang_q  <= angle_sat;
      end else begin
        l_idx_q  <= nclf_pkg::IDX_OUT_W'(pick_idx_q);
        l_dist_q <= dist_sat;
        l_ang_q  <= angle_sat;
      end
    end
  end

  // output register
  logic                          out_valid_q;
  logic [nclf_pkg::OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {1'b0,
                     l_lat_q ? l_ang_q  : '0,
                     l_lat_q ? l_dist_q : '0,
                     l_lat_q ? l_idx_q  : '0,
                     r_lat_q ? r_ang_q  : '0,
                     r_lat_q ? r_dist_q : '0,
                     r_lat_q ? r_idx_q  : '0,
                     l_lat_q, r_lat_q, r_lat_q && l_lat_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign status_o.enable        = enable_q;
  assign status_o.busy          = run_q || rdv_q;
  assign status_o.near_ok       = near_q < accept_q;
  assign status_o.hits_ok       = 32'(hits_q) > 32'(min_hits_q);
  assign status_o.right_latched = r_lat_q;
  assign status_o.left_latched  = l_lat_q;
  assign status_o.out_busy      = out_valid_q && !m_axis_tready;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("sample count beyond store depth");

  a_addr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && !cmd_i.pass_start |-> addr_q < hi)
    else $error("pass read beyond half bound");

  a_pick_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |-> pick_found_q)
    else $error("middle hit not found in pick pass");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> m_axis_tvalid)
    else $error("result not presented after emit");

endmodule

// ----- rtl/nearest_cluster_leg_finder.sv -----
// Top level of the nearest cluster leg finder: controller plus datapath.
//
// Takes one laser scan as a stream of sample requests (tuser = 0) and reports
// one result at each scan end while enabled; a restart request (tuser = 1)
// clears both latched legs. Samples are accepted one per cycle while idle
// into a MAX_POINTS deep scan memory; further samples of an overlong scan
// are dropped. After the last sample the block stops taking requests and,
// for each half without a latched leg, runs up to three passes over that
// half's samples (nearest range, hit count, middle hit), one memory read per
// cycle through the single read port, followed by the angle multiply and
// latch states. Requests are taken again once the result has been emitted;
// a pending result in the output register does not hold up input, only a
// second scan end. The scan memory has no reset and no clearing pass: only
// entries written during the current scan are read.
// Ranges are in mm, angles unsigned Q24 radians, distance saturates at 65535,
// angle at 2^27-1.
module nearest_cluster_leg_finder #(
  parameter int MAX_POINTS = 2048
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nclf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nclf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // sample stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] range_mm, [16] range_valid, [23:17] zero
  input  logic [nclf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] op
  input  logic                             s_axis_tuser,
  input  logic                             s_axis_tlast,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] aligned, [1] right_found, [2] left_found, [13:3] right_index,
  // [29:14] right_dist_mm, [56:30] right_angle_q24, [67:57] left_index,
  // [83:68] left_dist_mm, [110:84] left_angle_q24, [111] zero
  output logic [nclf_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  nclf_pkg::cmd_t    cmd;
  nclf_pkg::status_t status;

  // the user must change registers only while idle; the block does not enforce it, so writes are always taken
  assign cfg_ready_o = 1'b1;

  nclf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  nclf_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
